### rtl/core/matrix_row_operation_engine_assert.svh
// ----------------------------------------------------------------------------
// Matrix row operation engine assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_ROW_OPERATION_ENGINE_ASSERT_SVH
`define MATRIX_ROW_OPERATION_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MROE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MROE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mroe_pkg.sv
// ----------------------------------------------------------------------------
// mroe_pkg
// Types, sizes, operation codes and saturation helpers of the row engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mroe_pkg;

    localparam int ROWS_MAX    = 16;
    localparam int COLS_MAX    = 16;
    localparam int STORE_DEPTH = ROWS_MAX * COLS_MAX;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(COLS_MAX);
    localparam int ROW_W       = 4;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int PROD_W      = ROW_W + CNT_W;
    localparam int CFG_IDX_W   = 1;

    typedef logic signed [31:0] word_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_SCALE = 3'd2;
    localparam logic [2:0] KIND_ADD   = 3'd3;
    localparam logic [2:0] KIND_SWAP  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b1;

    localparam cnt_t CNT_RESET = 5'd16;

    typedef struct packed {
        logic [2:0]       kind;
        logic [ROW_W-1:0] row_a;
        logic [ROW_W-1:0] row_b;
        logic [IDX_W-1:0] col_index;
        word_t            value;
        word_t            factor;
    } in_item_t;

    typedef struct packed {
        word_t read_value;
        logic  error;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR_ELEM,
        ST_RD_ELEM,
        ST_MAC_RD_A,
        ST_MAC_RD_B,
        ST_MAC_RND,
        ST_MAC_SUM,
        ST_MAC_WR,
        ST_SWP_RD_A,
        ST_SWP_RD_B,
        ST_SWP_WR_A,
        ST_SWP_WR_B,
        ST_DONE
    } seq_state_t;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic word_t sat_word(input logic signed [63:0] x);
        word_t r;
        if (x > 64'sh0000_0000_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (x < 64'shFFFF_FFFF_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Clamp a count register to the range from 1 to limit.
    function automatic cnt_t clamp_count(input cnt_t raw, input int limit);
        cnt_t r;
        if (raw == '0)
        begin
            r = cnt_t'(1);
        end
        else if (raw > cnt_t'(limit))
        begin
            r = cnt_t'(limit);
        end
        else
        begin
            r = raw;
        end
        return r;
    endfunction

endpackage

### rtl/core/mroe_ram.sv
// ----------------------------------------------------------------------------
// mroe_ram
// Simple dual-port RAM: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mroe_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/mroe_mac.sv
// ----------------------------------------------------------------------------
// mroe_mac
// Three-stage Q16.16 multiply, round, saturate and saturating accumulate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mroe_mac (
    input  logic          clk,
    input  mroe_pkg::word_t mul_a,
    input  mroe_pkg::word_t mul_b,
    input  mroe_pkg::word_t addend,
    output mroe_pkg::word_t result
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    logic signed [63:0] biased;
    logic signed [63:0] shifted;
    mroe_pkg::word_t    rnd_reg;
    mroe_pkg::word_t    rnd_next;
    mroe_pkg::word_t    add_reg;
    logic signed [63:0] sum_wide;
    mroe_pkg::word_t    sum_reg;
    mroe_pkg::word_t    sum_next;

    assign prod_next = 64'(mul_a) * 64'(mul_b);

    // Adding half an LSB before the arithmetic shift rounds ties upward.
    assign biased   = prod_reg + 64'sh8000;
    assign shifted  = biased >>> 16;
    assign rnd_next = mroe_pkg::sat_word(shifted);

    assign sum_wide = 64'(rnd_reg) + 64'(add_reg);
    assign sum_next = mroe_pkg::sat_word(sum_wide);

    // The addend joins one stage after the operands, when the target word
    // has come back from memory.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rnd_reg  <= rnd_next;
        add_reg  <= addend;
        sum_reg  <= sum_next;
    end

    assign result = sum_reg;

endmodule

### rtl/core/matrix_row_operation_engine.sv
// ----------------------------------------------------------------------------
// matrix_row_operation_engine
// Q16.16 matrix store with element access and elementary row operations.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The engine takes one item at a time and
// holds in_stall high until the item is finished. A write or a read uses
// one store access. A scale or an add multiple goes column by column over the
// effective column count: read, multiply, round, sum, write back. A swap reads
// both rows' words of a column and then writes each into the other row. Every
// column passes through the single read and single write port of the store,
// and a scale or add multiple also through the three-stage multiply-accumulate
// unit. An item with an out-of-range index goes straight to the done state.
// The result sits in an output register, so a new item can be taken while it
// waits. The store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "matrix_row_operation_engine_assert.svh"

module matrix_row_operation_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mroe_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mroe_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [mroe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mroe_pkg::CNT_W-1:0]          cfg_data
);

    mroe_pkg::seq_state_t state_reg;
    mroe_pkg::seq_state_t state_next;

    mroe_pkg::cnt_t  num_cols_reg;
    mroe_pkg::cnt_t  num_rows_reg;
    mroe_pkg::cnt_t  cols_eff;
    mroe_pkg::cnt_t  rows_eff;
    mroe_pkg::cnt_t  cols_m1;

    logic [2:0]      kind_reg;
    mroe_pkg::word_t value_reg;
    mroe_pkg::word_t factor_reg;
    logic            err_reg;
    logic            err_now;
    mroe_pkg::addr_t base_a_reg;
    mroe_pkg::addr_t base_b_reg;
    mroe_pkg::addr_t base_a_next;
    mroe_pkg::addr_t base_b_next;
    logic [mroe_pkg::PROD_W-1:0] prod_a;
    logic [mroe_pkg::PROD_W-1:0] prod_b;
    mroe_pkg::col_t  col_reg;
    mroe_pkg::col_t  last_col_reg;
    logic            col_last;
    logic            col_step;
    mroe_pkg::word_t tmp_reg;
    logic            tmp_load;

    logic            accept;
    logic            row_op;
    mroe_pkg::addr_t addr_a;
    mroe_pkg::addr_t addr_b;

    logic            mem_we;
    mroe_pkg::addr_t mem_waddr;
    mroe_pkg::word_t mem_wdata;
    logic            mem_re;
    mroe_pkg::addr_t mem_raddr;
    mroe_pkg::word_t rd_data;

    mroe_pkg::word_t mac_addend;
    mroe_pkg::word_t mac_result;

    logic                out_load;
    logic                out_valid_reg;
    mroe_pkg::out_item_t out_data_reg;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= mroe_pkg::CNT_RESET;
            num_rows_reg <= mroe_pkg::CNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mroe_pkg::CFG_NUM_COLS: num_cols_reg <= cfg_data;
                mroe_pkg::CFG_NUM_ROWS: num_rows_reg <= cfg_data;
            endcase
        end
    end

    assign cols_eff = mroe_pkg::clamp_count(num_cols_reg, mroe_pkg::COLS_MAX);
    assign rows_eff = mroe_pkg::clamp_count(num_rows_reg, mroe_pkg::ROWS_MAX);
    assign cols_m1  = cols_eff - mroe_pkg::cnt_t'(1);

    // ------------------------------------------------------------------
    // Item decode at acceptance
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != mroe_pkg::ST_IDLE);
    assign accept   = in_valid && (state_reg == mroe_pkg::ST_IDLE);

    always_comb
    begin
        unique case (in_data.kind)
            mroe_pkg::KIND_WRITE,
            mroe_pkg::KIND_READ:
                err_now = (mroe_pkg::cnt_t'(in_data.row_a) >= rows_eff)
                       || (mroe_pkg::cnt_t'(in_data.col_index) >= cols_eff);
            mroe_pkg::KIND_SCALE:
                err_now = (mroe_pkg::cnt_t'(in_data.row_a) >= rows_eff);
            mroe_pkg::KIND_ADD,
            mroe_pkg::KIND_SWAP:
                err_now = (mroe_pkg::cnt_t'(in_data.row_a) >= rows_eff)
                       || (mroe_pkg::cnt_t'(in_data.row_b) >= rows_eff);
            default:
                err_now = 1'b0;
        endcase
    end

    assign row_op = (in_data.kind == mroe_pkg::KIND_SCALE)
                 || (in_data.kind == mroe_pkg::KIND_ADD)
                 || (in_data.kind == mroe_pkg::KIND_SWAP);

    assign prod_a = mroe_pkg::PROD_W'(in_data.row_a) * mroe_pkg::PROD_W'(cols_eff);
    assign prod_b = mroe_pkg::PROD_W'(in_data.row_b) * mroe_pkg::PROD_W'(cols_eff);
    assign base_a_next = mroe_pkg::ADDR_W'(prod_a);
    // A scale writes back into its own row, so its target base is row A.
    assign base_b_next = (in_data.kind == mroe_pkg::KIND_SCALE)
                       ? base_a_next : mroe_pkg::ADDR_W'(prod_b);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= in_data.kind;
            value_reg    <= in_data.value;
            factor_reg   <= in_data.factor;
            err_reg      <= err_now;
            base_a_reg   <= base_a_next;
            base_b_reg   <= base_b_next;
            last_col_reg <= cols_m1[mroe_pkg::COL_W-1:0];
            col_reg      <= row_op ? '0 : mroe_pkg::COL_W'(in_data.col_index);
        end
        else if (col_step)
        begin
            col_reg <= col_reg + mroe_pkg::col_t'(1);
        end
        if (tmp_load)
        begin
            tmp_reg <= rd_data;
        end
    end

    assign col_last = (col_reg == last_col_reg);
    assign addr_a   = base_a_reg + mroe_pkg::ADDR_W'(col_reg);
    assign addr_b   = base_b_reg + mroe_pkg::ADDR_W'(col_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mroe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mroe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (err_now)
                    begin
                        state_next = mroe_pkg::ST_DONE;
                    end
                    else
                    begin
                        unique case (in_data.kind)
                            mroe_pkg::KIND_WRITE: state_next = mroe_pkg::ST_WR_ELEM;
                            mroe_pkg::KIND_READ:  state_next = mroe_pkg::ST_RD_ELEM;
                            mroe_pkg::KIND_SCALE,
                            mroe_pkg::KIND_ADD:   state_next = mroe_pkg::ST_MAC_RD_A;
                            mroe_pkg::KIND_SWAP:  state_next = mroe_pkg::ST_SWP_RD_A;
                            default:              state_next = mroe_pkg::ST_DONE;
                        endcase
                    end
                end
            end
            mroe_pkg::ST_WR_ELEM:  state_next = mroe_pkg::ST_DONE;
            mroe_pkg::ST_RD_ELEM:  state_next = mroe_pkg::ST_DONE;
            mroe_pkg::ST_MAC_RD_A: state_next = mroe_pkg::ST_MAC_RD_B;
            mroe_pkg::ST_MAC_RD_B: state_next = mroe_pkg::ST_MAC_RND;
            mroe_pkg::ST_MAC_RND:  state_next = mroe_pkg::ST_MAC_SUM;
            mroe_pkg::ST_MAC_SUM:  state_next = mroe_pkg::ST_MAC_WR;
            mroe_pkg::ST_MAC_WR:
                state_next = col_last ? mroe_pkg::ST_DONE : mroe_pkg::ST_MAC_RD_A;
            mroe_pkg::ST_SWP_RD_A: state_next = mroe_pkg::ST_SWP_RD_B;
            mroe_pkg::ST_SWP_RD_B: state_next = mroe_pkg::ST_SWP_WR_A;
            mroe_pkg::ST_SWP_WR_A: state_next = mroe_pkg::ST_SWP_WR_B;
            mroe_pkg::ST_SWP_WR_B:
                state_next = col_last ? mroe_pkg::ST_DONE : mroe_pkg::ST_SWP_RD_A;
            mroe_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = mroe_pkg::ST_IDLE;
                end
            end
            default: state_next = mroe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_a;
        mem_wdata = value_reg;
        mem_re    = 1'b0;
        mem_raddr = addr_a;
        col_step  = 1'b0;
        tmp_load  = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            mroe_pkg::ST_WR_ELEM:
            begin
                mem_we = 1'b1;
            end
            mroe_pkg::ST_RD_ELEM,
            mroe_pkg::ST_MAC_RD_A,
            mroe_pkg::ST_SWP_RD_A:
            begin
                mem_re = 1'b1;
            end
            mroe_pkg::ST_MAC_RD_B:
            begin
                // Only an add multiple needs the target word as addend.
                mem_re    = (kind_reg == mroe_pkg::KIND_ADD);
                mem_raddr = addr_b;
            end
            mroe_pkg::ST_MAC_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_b;
                mem_wdata = mac_result;
                col_step  = !col_last;
            end
            mroe_pkg::ST_SWP_RD_B:
            begin
                mem_re    = 1'b1;
                mem_raddr = addr_b;
                tmp_load  = 1'b1;
            end
            mroe_pkg::ST_SWP_WR_A:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data;
            end
            mroe_pkg::ST_SWP_WR_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_b;
                mem_wdata = tmp_reg;
                col_step  = !col_last;
            end
            mroe_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Store and arithmetic unit
    // ------------------------------------------------------------------
    mroe_ram #(
        .DEPTH (mroe_pkg::STORE_DEPTH),
        .WIDTH (32)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    assign mac_addend = (kind_reg == mroe_pkg::KIND_ADD) ? rd_data : '0;

    mroe_mac u_mac (
        .clk    (clk),
        .mul_a  (factor_reg),
        .mul_b  (rd_data),
        .addend (mac_addend),
        .result (mac_result)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.error      <= err_reg;
            out_data_reg.read_value <= ((kind_reg == mroe_pkg::KIND_READ) && !err_reg)
                                     ? rd_data : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MROE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "engine took an item but did not go busy")

    `MROE_ASSERT_NEXT(a_result_loaded, out_load, out_valid,
        "finished item did not present a result beat")

    `MROE_ASSERT_SAME(a_write_states, mem_we,
        (state_reg == mroe_pkg::ST_WR_ELEM) || (state_reg == mroe_pkg::ST_MAC_WR) ||
        (state_reg == mroe_pkg::ST_SWP_WR_A) || (state_reg == mroe_pkg::ST_SWP_WR_B),
        "store written outside a write step")

    `MROE_ASSERT_SAME(a_error_no_data, out_valid && out_data.error,
        out_data.read_value == '0, "error beat carries a nonzero value")

    `MROE_ASSERT_SAME(a_no_store_on_error, mem_we, !err_reg,
        "store written for an item with a range error")

endmodule
